[rtl/mbcc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbcc_pkg
// Shared types, opcodes and constants for the multi-box collision checker.
// ----------------------------------------------------------------------------
package mbcc_pkg;

    localparam int MAX_BOXES_DEF = 16;

    localparam int S_TDATA_W = 96;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 72;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_TEST  = 2'd2;
    localparam logic [1:0] OP_QUERY = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LAUNCH,
        ST_RUN,
        ST_FINISH
    } state_t;

    // one stored box
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic        [14:0] w;
        logic        [14:0] h;
    } box_t;

    // shifted test box travelling down the cell row
    typedef struct packed {
        logic               valid;
        logic               hit;
        logic signed [16:0] tx;
        logic signed [16:0] ty;
        logic        [14:0] w;
        logic        [14:0] h;
    } probe_t;

endpackage

[rtl/mbcc_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbcc_cell
// One table slot: holds a box, checks the passing probe against it, and
// hands the probe with its updated hit bit to the next cell.
// ----------------------------------------------------------------------------
module mbcc_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 5
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [CNT_W-1:0]     box_count,
    input  logic                 wr_en,
    input  mbcc_pkg::box_t       wr_box,
    input  mbcc_pkg::probe_t     probe_in,
    output mbcc_pkg::probe_t     probe_out
);
    import mbcc_pkg::*;

    box_t               box_reg;
    probe_t             probe_reg;
    probe_t             probe_next;
    logic               occupied;
    logic               overlap;
    logic signed [17:0] t_right;
    logic signed [17:0] t_bottom;
    logic signed [16:0] s_right;
    logic signed [16:0] s_bottom;
    logic signed [17:0] s_left;
    logic signed [17:0] s_top;

    // slot is live only below the fill count
    assign occupied = (box_count > CNT_W'(INDEX));

    always_comb begin
        t_right  = $signed({probe_in.tx[16], probe_in.tx}) + $signed({3'b000, probe_in.w});
        t_bottom = $signed({probe_in.ty[16], probe_in.ty}) + $signed({3'b000, probe_in.h});
        s_right  = $signed({box_reg.x[15], box_reg.x}) + $signed({2'b00, box_reg.w});
        s_bottom = $signed({box_reg.y[15], box_reg.y}) + $signed({2'b00, box_reg.h});
        s_left   = $signed({{2{box_reg.x[15]}}, box_reg.x});
        s_top    = $signed({{2{box_reg.y[15]}}, box_reg.y});
        // strict overlap: touching edges do not count
        overlap  = (s_left < t_right) && (s_right > $signed(probe_in.tx)) &&
                   (s_top < t_bottom) && (s_bottom > $signed(probe_in.ty));
        probe_next     = probe_in;
        probe_next.hit = probe_in.hit | (probe_in.valid & occupied & overlap);
    end

    always_ff @(posedge aclk) begin
        if (wr_en && (box_count == CNT_W'(INDEX))) begin
            box_reg <= wr_box;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            probe_reg.valid <= 1'b0;
        end else begin
            probe_reg <= probe_next;
        end
    end

    assign probe_out = probe_reg;

endmodule

[rtl/multi_box_collision_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_box_collision_checker
// Box table with running bounding box and strict-overlap test of shifted boxes.
// ----------------------------------------------------------------------------
// The block works on one transaction at a time. Clear, load and query go from
// idle to the finish state, where the result is written to the output
// register. A test passes through a launch and a run state first, in which the
// shifted box walks through the row of MAX_BOXES cells, one cell per cycle,
// each cell comparing against the box it holds, before the finish state.
// After a transaction is accepted, s_tready stays low until its result has been
// written to the output register; a result waiting on m_tready does not block
// the next input transaction from being accepted, only from completing. Every
// result carries the bounding box as it stands after the operation (all zero
// when the table is empty). A load into a full table is dropped and flagged
// with status.
// ----------------------------------------------------------------------------
module multi_box_collision_checker #(
    parameter int MAX_BOXES = mbcc_pkg::MAX_BOXES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input channel
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // box_x[15:0], box_y[31:16], box_w[46:32], box_h[61:47],
    // offset_x[77:62], offset_y[93:78], zero pad[95:94]
    input  logic [mbcc_pkg::S_TDATA_W-1:0] s_tdata,
    // opcode[1:0]
    input  logic [mbcc_pkg::S_TUSER_W-1:0] s_tuser,
    // last_box
    input  logic                           s_tlast,
    // result channel
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // status[0], box_hit[1], form_hit[2], bbox_valid[3], bbox_left[19:4],
    // bbox_top[35:20], bbox_width[52:36], bbox_height[69:53], zero pad[71:70]
    output logic [mbcc_pkg::M_TDATA_W-1:0] m_tdata
);
    import mbcc_pkg::*;

    localparam int CNT_W = $clog2(MAX_BOXES + 1);

    // --- input field unpacking
    logic signed [15:0] in_box_x;
    logic signed [15:0] in_box_y;
    logic        [14:0] in_box_w;
    logic        [14:0] in_box_h;
    logic signed [15:0] in_offset_x;
    logic signed [15:0] in_offset_y;

    assign in_box_x    = s_tdata[15:0];
    assign in_box_y    = s_tdata[31:16];
    assign in_box_w    = s_tdata[46:32];
    assign in_box_h    = s_tdata[61:47];
    assign in_offset_x = s_tdata[77:62];
    assign in_offset_y = s_tdata[93:78];

    // --- control
    state_t state_reg;
    state_t state_next;
    logic   accept;
    logic   launch;
    logic   commit;
    logic   probe_done;

    // --- latched transaction
    logic [1:0]         op_reg;
    logic               last_reg;
    box_t               box_reg;
    logic signed [16:0] tx_reg;
    logic signed [16:0] ty_reg;
    logic signed [16:0] right_reg;
    logic signed [16:0] bottom_reg;
    logic               hit_reg;

    // --- architectural state
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               form_flag_reg;
    logic               form_flag_next;
    logic signed [15:0] min_left_reg;
    logic signed [15:0] min_left_next;
    logic signed [15:0] min_top_reg;
    logic signed [15:0] min_top_next;
    logic signed [16:0] max_right_reg;
    logic signed [16:0] max_right_next;
    logic signed [16:0] max_bottom_reg;
    logic signed [16:0] max_bottom_next;

    // --- result
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TDATA_W-1:0] m_tdata_next;

    logic               table_full;
    logic               load_ok;
    logic               first_box;
    logic               res_status;
    logic               res_box_hit;
    logic               res_form_hit;
    logic               res_bbox_valid;
    logic signed [17:0] res_width;
    logic signed [17:0] res_height;

    // --- cell row
    probe_t probe_launch;
    probe_t chain [0:MAX_BOXES];

    assign accept     = s_tvalid && s_tready;
    assign probe_done = chain[MAX_BOXES].valid;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = (s_tuser == OP_TEST) ? ST_LAUNCH : ST_FINISH;
                end
            end
            ST_LAUNCH: begin
                state_next = ST_RUN;
            end
            ST_RUN: begin
                if (probe_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (commit) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb begin
        s_tready = 1'b0;
        launch   = 1'b0;
        commit   = 1'b0;
        case (state_reg)
            ST_IDLE:   s_tready = 1'b1;
            ST_LAUNCH: launch   = 1'b1;
            ST_FINISH: commit   = !m_tvalid_reg || m_tready;
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // latch the transaction; shifted edges and loaded far edges are
    // precomputed here to keep the commit path short
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg     <= s_tuser;
            last_reg   <= s_tlast;
            box_reg.x  <= in_box_x;
            box_reg.y  <= in_box_y;
            box_reg.w  <= in_box_w;
            box_reg.h  <= in_box_h;
            tx_reg     <= $signed({in_box_x[15], in_box_x}) +
                          $signed({in_offset_x[15], in_offset_x});
            ty_reg     <= $signed({in_box_y[15], in_box_y}) +
                          $signed({in_offset_y[15], in_offset_y});
            right_reg  <= $signed({in_box_x[15], in_box_x}) + $signed({2'b00, in_box_w});
            bottom_reg <= $signed({in_box_y[15], in_box_y}) + $signed({2'b00, in_box_h});
        end
        if ((state_reg == ST_RUN) && probe_done) begin
            hit_reg <= chain[MAX_BOXES].hit;
        end
    end

    // probe enters cell 0 for one cycle
    always_comb begin
        probe_launch.valid = launch;
        probe_launch.hit   = 1'b0;
        probe_launch.tx    = tx_reg;
        probe_launch.ty    = ty_reg;
        probe_launch.w     = box_reg.w;
        probe_launch.h     = box_reg.h;
    end

    assign chain[0] = probe_launch;

    // cell k holds table entry k; loads land in the cell matching the count
    for (genvar k = 0; k < MAX_BOXES; k++) begin : g_cell
        mbcc_cell #(
            .INDEX (k),
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .box_count (count_reg),
            .wr_en     (commit && load_ok),
            .wr_box    (box_reg),
            .probe_in  (chain[k]),
            .probe_out (chain[k+1])
        );
    end

    // state update applied at commit
    always_comb begin
        table_full      = (count_reg == CNT_W'(MAX_BOXES));
        load_ok         = (op_reg == OP_LOAD) && !table_full;
        first_box       = (count_reg == '0);
        count_next      = count_reg;
        form_flag_next  = form_flag_reg;
        min_left_next   = min_left_reg;
        min_top_next    = min_top_reg;
        max_right_next  = max_right_reg;
        max_bottom_next = max_bottom_reg;
        res_status      = 1'b0;
        res_box_hit     = 1'b0;
        res_form_hit    = 1'b0;
        case (op_reg)
            OP_CLEAR: begin
                count_next      = '0;
                form_flag_next  = 1'b0;
                min_left_next   = '0;
                min_top_next    = '0;
                max_right_next  = '0;
                max_bottom_next = '0;
            end
            OP_LOAD: begin
                if (table_full) begin
                    res_status = 1'b1;
                end else begin
                    count_next = count_reg + CNT_W'(1);
                    if (first_box || (box_reg.x < min_left_reg)) begin
                        min_left_next = box_reg.x;
                    end
                    if (first_box || (box_reg.y < min_top_reg)) begin
                        min_top_next = box_reg.y;
                    end
                    if (first_box || (right_reg > max_right_reg)) begin
                        max_right_next = right_reg;
                    end
                    if (first_box || (bottom_reg > max_bottom_reg)) begin
                        max_bottom_next = bottom_reg;
                    end
                end
            end
            OP_TEST: begin
                res_box_hit    = hit_reg;
                res_form_hit   = form_flag_reg || hit_reg;
                form_flag_next = last_reg ? 1'b0 : res_form_hit;
            end
            default: begin
                count_next = count_reg;
            end
        endcase

        res_bbox_valid = (count_next != '0);
        res_width      = $signed({max_right_next[16], max_right_next}) -
                         $signed({{2{min_left_next[15]}}, min_left_next});
        res_height     = $signed({max_bottom_next[16], max_bottom_next}) -
                         $signed({{2{min_top_next[15]}}, min_top_next});

        m_tdata_next      = '0;
        m_tdata_next[0]   = res_status;
        m_tdata_next[1]   = res_box_hit;
        m_tdata_next[2]   = res_form_hit;
        m_tdata_next[3]   = res_bbox_valid;
        if (res_bbox_valid) begin
            m_tdata_next[19:4]  = min_left_next;
            m_tdata_next[35:20] = min_top_next;
            m_tdata_next[52:36] = res_width[16:0];
            m_tdata_next[69:53] = res_height[16:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            form_flag_reg  <= 1'b0;
            min_left_reg   <= '0;
            min_top_reg    <= '0;
            max_right_reg  <= '0;
            max_bottom_reg <= '0;
        end else if (commit) begin
            count_reg      <= count_next;
            form_flag_reg  <= form_flag_next;
            min_left_reg   <= min_left_next;
            min_top_reg    <= min_top_next;
            max_right_reg  <= max_right_next;
            max_bottom_reg <= max_bottom_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (commit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

[rtl/mbcc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbcc_checker
// Port-level assertions for the multi-box collision checker, bound to the top.
// ----------------------------------------------------------------------------
module mbcc_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [mbcc_pkg::M_TDATA_W-1:0] m_tdata
);
    import mbcc_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one transaction in flight: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second transaction accepted while busy");

    // full-table status only on loads, hits only on tests
    a_status_hit_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && (m_tdata[1] || m_tdata[2])))
        else $error("status and hit flags set together");

    // a box hit always sets the form hit
    a_box_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1] |-> m_tdata[2])
        else $error("box hit without form hit");

    // empty table reports an all-zero bounding box
    a_empty_bbox: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[3] |-> (m_tdata[69:4] == '0))
        else $error("bounding box nonzero while table empty");

endmodule

bind multi_box_collision_checker mbcc_checker u_mbcc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
